// ----- rtl/core/sfc_pkg.sv -----
package sfc_pkg;

    // Default widths
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int DEF_CHANNEL_BITS = 8;

    // Q1.16 fraction of the color scale: 0 .. ONE_Q16
    localparam int FRAC_BITS = 16;
    localparam int Q_BITS    = FRAC_BITS + 1;
    localparam int ONE_Q16   = 1 << FRAC_BITS;
    localparam int HALF_Q16  = 1 << (FRAC_BITS - 1);

    // Rainbow hue: h6 = floor((21*u + 2) / 5), division done by reciprocal
    localparam int               HUE_SCALE  = 21;
    localparam int               HUE_ROUND  = 2;
    localparam int               HUE_X_BITS = 21;
    localparam logic [20:0]      RCP_DIV5   = 21'd1677722;
    localparam int               RCP_SHIFT  = 23;
    localparam int               HPROD_BITS = 2 * HUE_X_BITS;
    localparam int               H6_BITS    = 19;

    // Jet ramp breakpoints
    localparam logic signed [18:0] JET_OUTER = 19'sd49152;
    localparam logic signed [18:0] JET_INNER = 19'sd16384;
    localparam logic signed [18:0] JET_SHIFT = 19'sd32768;
    localparam logic signed [18:0] JET_ONE   = 19'sd65536;

    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LOW_BOUND  = 2'd0,
        REG_HIGH_BOUND = 2'd1,
        REG_MAP_MODE   = 2'd2,
        REG_BLUE_FIRST = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_RAINBOW = 2'd0,
        MODE_JET     = 2'd1,
        MODE_GRAY    = 2'd2
    } map_mode_t;

    typedef enum logic [2:0] {
        SECT_RED_YELLOW  = 3'd0,
        SECT_YELLOW_GRN  = 3'd1,
        SECT_GRN_CYAN    = 3'd2,
        SECT_CYAN_BLUE   = 3'd3,
        SECT_BLUE_MAG    = 3'd4,
        SECT_MAG_RED     = 3'd5
    } hue_sector_t;

    // Control that travels with each pipeline slot
    typedef struct packed {
        logic valid;
        logic range_error;
    } sfc_tag_t;

    // Piecewise-linear jet ramp, result in Q16
    function automatic logic [Q_BITS-1:0] jet_ramp(input logic signed [18:0] x);
        logic signed [18:0] rise;
        logic signed [18:0] fall;
        logic [Q_BITS-1:0]  res;
        rise = x + JET_OUTER;
        fall = JET_OUTER - x;
        if (x <= -JET_OUTER)
            res = '0;
        else if (x <= -JET_INNER)
            res = {rise[FRAC_BITS-1:0], 1'b0};
        else if (x <= JET_INNER)
            res = Q_BITS'(ONE_Q16);
        else if (x <= JET_OUTER)
            res = {fall[FRAC_BITS-1:0], 1'b0};
        else
            res = '0;
        return res;
    endfunction

endpackage

// ----- rtl/core/sfc_sample_if.sv -----
interface sfc_sample_if #(
    parameter int SAMPLE_BITS = sfc_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/core/sfc_pixel_if.sv -----
interface sfc_pixel_if #(
    parameter int CHANNEL_BITS = sfc_pkg::DEF_CHANNEL_BITS
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] chan0;
    logic [CHANNEL_BITS-1:0] chan1;
    logic [CHANNEL_BITS-1:0] chan2;
    logic                    range_error;

    modport source (output valid, output chan0, output chan1, output chan2,
                    output range_error, input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2,
                    input range_error, output ready);
endinterface

// ----- rtl/core/sfc_divider.sv -----
module sfc_divider #(
    parameter int SAMPLE_BITS = sfc_pkg::DEF_SAMPLE_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  sfc_pkg::sfc_tag_t          in_tag,
    input  logic [SAMPLE_BITS-1:0]     numer,
    input  logic [SAMPLE_BITS-1:0]     divisor,
    output sfc_pkg::sfc_tag_t          out_tag,
    output logic [sfc_pkg::Q_BITS-1:0] quotient
);
    import sfc_pkg::*;

    localparam int NUM_W = SAMPLE_BITS + Q_BITS;
    localparam int LAST  = Q_BITS - 1;

    // Rounded dividend: numer * 2^16 + divisor / 2
    logic [NUM_W-1:0] dividend;
    assign dividend = NUM_W'({numer, {FRAC_BITS{1'b0}}}) + NUM_W'(divisor >> 1);

    sfc_tag_t               tag_reg  [Q_BITS];
    logic [SAMPLE_BITS-1:0] rem_reg  [Q_BITS];
    logic [Q_BITS-1:0]      bits_reg [Q_BITS];

    sfc_tag_t               tag_in   [Q_BITS];
    logic [SAMPLE_BITS-1:0] rem_in   [Q_BITS];
    logic [Q_BITS-1:0]      bits_in  [Q_BITS];
    logic [SAMPLE_BITS:0]   trial    [Q_BITS];
    logic                   fits     [Q_BITS];
    logic [SAMPLE_BITS-1:0] rem_next [Q_BITS];
    logic [Q_BITS-1:0]      bits_next[Q_BITS];

    // One restoring step per stage; dividend bits shift out at the top while
    // quotient bits shift in at the bottom of the same word.
    for (genvar k = 0; k < Q_BITS; k++)
    begin : g_step
        if (k == 0)
        begin : g_head
            assign tag_in[k]  = in_tag;
            assign rem_in[k]  = dividend[NUM_W-1:Q_BITS];
            assign bits_in[k] = dividend[Q_BITS-1:0];
        end
        else
        begin : g_body
            assign tag_in[k]  = tag_reg[k-1];
            assign rem_in[k]  = rem_reg[k-1];
            assign bits_in[k] = bits_reg[k-1];
        end

        assign trial[k]     = {rem_in[k], bits_in[k][Q_BITS-1]};
        assign fits[k]      = trial[k] >= {1'b0, divisor};
        assign rem_next[k]  = fits[k] ? SAMPLE_BITS'(trial[k] - {1'b0, divisor})
                                      : trial[k][SAMPLE_BITS-1:0];
        assign bits_next[k] = {bits_in[k][Q_BITS-2:0], fits[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[k] <= '0;
            else if (advance)
                tag_reg[k] <= tag_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k]  <= rem_next[k];
                bits_reg[k] <= bits_next[k];
            end
        end
    end

    assign out_tag  = tag_reg[LAST];
    assign quotient = bits_reg[LAST];

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg[LAST].valid && !tag_reg[LAST].range_error |-> rem_reg[LAST] < divisor)
        else $error("divider remainder not below divisor");

endmodule

// ----- rtl/core/scalar_to_false_color.sv -----
// Throughput: one sample per cycle; the whole pipeline holds while the output stalls.
// Depth: one front stage, 17 divider stages (one quotient bit each), three color stages.
// Reset (rst_n, async, active low) empties the pipeline and loads the register
// defaults: low bound 0, high bound 1, rainbow mode, red-green-blue order.
module scalar_to_false_color #(
    parameter int SAMPLE_BITS  = sfc_pkg::DEF_SAMPLE_BITS,
    parameter int CHANNEL_BITS = sfc_pkg::DEF_CHANNEL_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [sfc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]             cfg_data,
    sfc_sample_if.sink                         samples,
    sfc_pixel_if.source                        pixels
);
    import sfc_pkg::*;

    localparam int                      SCALE_BITS = Q_BITS + CHANNEL_BITS + 1;
    localparam logic [CHANNEL_BITS-1:0] CH_MAX     = '1;

    // ------------------------------------------------------------------
    // Configuration registers, read directly, not copied. Writes must
    // arrive only while the pipeline is empty; the block does not check.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] low_bound_reg;
    logic signed [SAMPLE_BITS-1:0] high_bound_reg;
    logic [1:0]                    map_mode_reg;
    logic                          blue_first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bound_reg  <= '0;
            high_bound_reg <= SAMPLE_BITS'(1);
            map_mode_reg   <= MODE_RAINBOW;
            blue_first_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LOW_BOUND:  low_bound_reg  <= cfg_data;
                REG_HIGH_BOUND: high_bound_reg <= cfg_data;
                REG_MAP_MODE:   map_mode_reg   <= cfg_data[1:0];
                REG_BLUE_FIRST: blue_first_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: every stage advances together whenever the output
    // register is empty or its transaction completes this cycle. Bubbles
    // travel as invalid slots, so nothing is dropped or repeated on a stall.
    // ------------------------------------------------------------------
    logic advance;
    assign advance       = !pixels.valid || pixels.ready;
    assign samples.ready = advance;

    // ------------------------------------------------------------------
    // Front stage: span of the bounds, range check, clamp the sample offset
    // into [0, span].
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS:0]   span;
    logic signed [SAMPLE_BITS:0]   offset;
    logic                          bad_range;
    logic [SAMPLE_BITS-1:0]        clamped;
    logic [SAMPLE_BITS-1:0]        divisor;

    assign span      = $signed({high_bound_reg[SAMPLE_BITS-1], high_bound_reg})
                     - $signed({low_bound_reg[SAMPLE_BITS-1], low_bound_reg});
    assign offset    = $signed({samples.sample[SAMPLE_BITS-1], samples.sample})
                     - $signed({low_bound_reg[SAMPLE_BITS-1], low_bound_reg});
    assign bad_range = span[SAMPLE_BITS] || (span == '0);
    assign divisor   = span[SAMPLE_BITS-1:0];

    always_comb
    begin
        if (offset[SAMPLE_BITS])
            clamped = '0;
        else if (offset > span)
            clamped = span[SAMPLE_BITS-1:0];
        else
            clamped = offset[SAMPLE_BITS-1:0];
    end

    sfc_tag_t               front_tag_reg;
    logic [SAMPLE_BITS-1:0] front_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_tag_reg <= '0;
        else if (advance)
            front_tag_reg <= '{valid: samples.valid, range_error: bad_range};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            front_num_reg <= clamped;
    end

    // ------------------------------------------------------------------
    // Divider: t = round(offset * 2^16 / span), Q1.16 in 0 .. 65536.
    // ------------------------------------------------------------------
    sfc_tag_t          div_tag;
    logic [Q_BITS-1:0] div_t;

    sfc_divider #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_tag   (front_tag_reg),
        .numer    (front_num_reg),
        .divisor  (divisor),
        .out_tag  (div_tag),
        .quotient (div_t)
    );

    // ------------------------------------------------------------------
    // Color stage 1: rainbow hue. h6 = hue/60 in Q16, taken as
    // (21*(1-t) + 2) / 5 through a multiply by the reciprocal of five.
    // ------------------------------------------------------------------
    logic [Q_BITS-1:0]     hue_u;
    logic [HUE_X_BITS-1:0] hue_x;

    assign hue_u = Q_BITS'(ONE_Q16) - div_t;
    assign hue_x = HUE_X_BITS'(hue_u * HUE_SCALE + HUE_ROUND);

    sfc_tag_t              c1_tag_reg;
    logic [Q_BITS-1:0]     c1_t_reg;
    logic [HPROD_BITS-1:0] c1_hprod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c1_tag_reg <= '0;
        else if (advance)
            c1_tag_reg <= div_tag;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c1_t_reg     <= div_t;
            c1_hprod_reg <= hue_x * RCP_DIV5;
        end
    end

    // ------------------------------------------------------------------
    // Color stage 2: per-mode red, green and blue in Q16.
    // ------------------------------------------------------------------
    logic [H6_BITS-1:0]    h6;
    logic [2:0]            sector;
    logic [Q_BITS-1:0]     frac;
    logic [Q_BITS-1:0]     frac_inv;
    logic signed [18:0]    jet_v;
    logic [Q_BITS-1:0]     red_q;
    logic [Q_BITS-1:0]     green_q;
    logic [Q_BITS-1:0]     blue_q;

    assign h6       = c1_hprod_reg[RCP_SHIFT +: H6_BITS];
    assign sector   = h6[H6_BITS-1:FRAC_BITS];
    assign frac     = {1'b0, h6[FRAC_BITS-1:0]};
    assign frac_inv = Q_BITS'(ONE_Q16) - frac;
    assign jet_v    = $signed({1'b0, c1_t_reg, 1'b0}) - JET_ONE;

    always_comb
    begin
        red_q   = c1_t_reg;
        green_q = c1_t_reg;
        blue_q  = c1_t_reg;
        case (map_mode_reg)
            MODE_RAINBOW:
            begin
                case (sector)
                    SECT_RED_YELLOW:
                    begin
                        red_q = Q_BITS'(ONE_Q16); green_q = frac; blue_q = '0;
                    end
                    SECT_YELLOW_GRN:
                    begin
                        red_q = frac_inv; green_q = Q_BITS'(ONE_Q16); blue_q = '0;
                    end
                    SECT_GRN_CYAN:
                    begin
                        red_q = '0; green_q = Q_BITS'(ONE_Q16); blue_q = frac;
                    end
                    SECT_CYAN_BLUE:
                    begin
                        red_q = '0; green_q = frac_inv; blue_q = Q_BITS'(ONE_Q16);
                    end
                    SECT_BLUE_MAG:
                    begin
                        red_q = frac; green_q = '0; blue_q = Q_BITS'(ONE_Q16);
                    end
                    default:
                    begin
                        red_q = Q_BITS'(ONE_Q16); green_q = '0; blue_q = frac_inv;
                    end
                endcase
            end
            MODE_JET:
            begin
                red_q   = jet_ramp(jet_v - JET_SHIFT);
                green_q = jet_ramp(jet_v);
                blue_q  = jet_ramp(jet_v + JET_SHIFT);
            end
            default:
            begin
                // gray, and the unused mode code behaves as gray
                red_q   = c1_t_reg;
                green_q = c1_t_reg;
                blue_q  = c1_t_reg;
            end
        endcase
    end

    sfc_tag_t          c2_tag_reg;
    logic [Q_BITS-1:0] c2_red_reg;
    logic [Q_BITS-1:0] c2_green_reg;
    logic [Q_BITS-1:0] c2_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c2_tag_reg <= '0;
        else if (advance)
            c2_tag_reg <= c1_tag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c2_red_reg   <= red_q;
            c2_green_reg <= green_q;
            c2_blue_reg  <= blue_q;
        end
    end

    // ------------------------------------------------------------------
    // Color stage 3: scale Q16 to the channel range with rounding, pick the
    // channel order, force zero on a bad range. This is the output register.
    // ------------------------------------------------------------------
    function automatic logic [CHANNEL_BITS-1:0] scale_chan(input logic [Q_BITS-1:0] x);
        logic [SCALE_BITS-1:0] acc;
        acc = SCALE_BITS'({x, {CHANNEL_BITS{1'b0}}}) - SCALE_BITS'(x)
            + SCALE_BITS'(HALF_Q16);
        return acc[FRAC_BITS +: CHANNEL_BITS];
    endfunction

    logic [CHANNEL_BITS-1:0] red_c;
    logic [CHANNEL_BITS-1:0] green_c;
    logic [CHANNEL_BITS-1:0] blue_c;
    logic [CHANNEL_BITS-1:0] chan0_next;
    logic [CHANNEL_BITS-1:0] chan1_next;
    logic [CHANNEL_BITS-1:0] chan2_next;

    assign red_c   = scale_chan(c2_red_reg);
    assign green_c = scale_chan(c2_green_reg);
    assign blue_c  = scale_chan(c2_blue_reg);

    always_comb
    begin
        chan1_next = green_c;
        if (blue_first_reg)
        begin
            chan0_next = blue_c;
            chan2_next = red_c;
        end
        else
        begin
            chan0_next = red_c;
            chan2_next = blue_c;
        end
        if (c2_tag_reg.range_error)
        begin
            chan0_next = '0;
            chan1_next = '0;
            chan2_next = '0;
        end
    end

    logic                    out_valid_reg;
    logic                    out_error_reg;
    logic [CHANNEL_BITS-1:0] out_chan0_reg;
    logic [CHANNEL_BITS-1:0] out_chan1_reg;
    logic [CHANNEL_BITS-1:0] out_chan2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= c2_tag_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_error_reg <= c2_tag_reg.range_error;
            out_chan0_reg <= chan0_next;
            out_chan1_reg <= chan1_next;
            out_chan2_reg <= chan2_next;
        end
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.range_error = out_error_reg;
    assign pixels.chan0       = out_chan0_reg;
    assign pixels.chan1       = out_chan1_reg;
    assign pixels.chan2       = out_chan2_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_t_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        c1_tag_reg.valid && !c1_tag_reg.range_error |-> c1_t_reg <= Q_BITS'(ONE_Q16))
        else $error("normalized sample above one");

    a_error_blank: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && pixels.range_error
            |-> pixels.chan0 == '0 && pixels.chan1 == '0 && pixels.chan2 == '0)
        else $error("range error pixel not blank");

    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && !pixels.range_error && map_mode_reg == MODE_GRAY
            |-> pixels.chan0 == pixels.chan1 && pixels.chan1 == pixels.chan2)
        else $error("gray pixel channels differ");

    a_rainbow_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && !pixels.range_error && map_mode_reg == MODE_RAINBOW
            |-> pixels.chan0 == CH_MAX || pixels.chan1 == CH_MAX
                || pixels.chan2 == CH_MAX)
        else $error("rainbow pixel has no saturated channel");

endmodule
